/* src/lppf_pkg.sv */
// lppf_pkg: shared types, codes and defaults for the length-prefixed packet fifo
// used by lppf_out_q and length_prefixed_packet_fifo; no dependencies
package lppf_pkg;

    // default sizing, handed to the top-level parameters
    localparam int DEF_STORE_DEPTH      = 8192;
    localparam int DEF_MAX_PACKET_WORDS = 4096;
    localparam int DEF_WORD_BITS        = 16;

    // fixed field widths of the ports
    localparam int ACTION_BITS = 2;
    localparam int LEN_BITS    = 13;
    localparam int DATA_BITS   = 16;
    localparam int STATUS_BITS = 2;

    // transaction codes on the input side
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_HEADER = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_POP    = 2'd2
    } t_action;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SEQ   = 2'd3
    } t_status;

    // word kind of a popped word
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // one result transaction
    typedef struct packed {
        t_status              status;
        logic                 word_kind;
        logic [DATA_BITS-1:0] read_word;
        logic                 last_of_packet;
    } t_result;

endpackage

/* src/length_prefixed_packet_fifo.sv */
// length_prefixed_packet_fifo: top level, packet fifo control around one word store
// depends on lppf_pkg, lppf_ram and lppf_out_q
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------------------
//  input   | i_valid | o_ready | i_action, i_packet_length, i_data_word
//  output  | o_valid | i_ready | o_status, o_word_kind, o_read_word, o_last_of_packet
//
// a pop that returns a word reads the store through its registered read port;
// its result is built while r_pop_wait is set, when the input is not ready.
// a two-entry result queue lets the input run while a result waits to be taken;
// o_ready also drops when that queue is full.
// synchronous active-low reset clears all pointers and counts but r_push_len;
// store contents are not cleared and need no clearing pass.
module length_prefixed_packet_fifo
    import lppf_pkg::*;
#(
    parameter int STORE_DEPTH      = DEF_STORE_DEPTH,
    parameter int MAX_PACKET_WORDS = DEF_MAX_PACKET_WORDS,
    parameter int WORD_BITS        = DEF_WORD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ACTION_BITS-1:0] i_action,
    input  logic [LEN_BITS-1:0]    i_packet_length,
    input  logic [DATA_BITS-1:0]   i_data_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_BITS-1:0] o_status,
    output logic                   o_word_kind,
    output logic [DATA_BITS-1:0]   o_read_word,
    output logic                   o_last_of_packet
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int UW = $clog2(STORE_DEPTH + 1);
    localparam int CW = (UW > LEN_BITS + 1) ? UW : LEN_BITS + 1;

    // pointers and counts
    logic [PW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [UW-1:0]       r_words_used, n_words_used;
    logic [UW-1:0]       r_readable, n_readable;
    logic                r_push_open, n_push_open;
    logic [LEN_BITS-1:0] r_push_left, n_push_left;
    logic [LEN_BITS-1:0] r_push_len, n_push_len;
    logic                r_pop_open, n_pop_open;
    logic [LEN_BITS-1:0] r_pop_left, n_pop_left;
    logic                r_pop_wait, n_pop_wait;
    logic                r_pop_hdr, n_pop_hdr;

    // store port and result signals
    logic                 w_accept;
    logic                 w_wr_en;
    logic [WORD_BITS-1:0] w_wr_data;
    logic                 w_rd_en;
    logic [WORD_BITS-1:0] w_rd_data;
    logic [LEN_BITS-1:0]  w_hdr_len;
    logic [CW-1:0]        w_free;
    logic [CW-1:0]        w_need;
    logic                 w_enq;
    t_result              w_res;
    t_result              w_head;
    logic                 w_q_full;

    assign o_ready  = !r_pop_wait && !w_q_full;
    assign w_accept = i_valid && o_ready;

    // room test for a header: free words against header plus data
    assign w_free    = CW'(UW'(STORE_DEPTH) - r_words_used);
    assign w_need    = CW'(i_packet_length) + CW'(1);
    assign w_hdr_len = LEN_BITS'(w_rd_data);

    // transaction decode and state update
    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_words_used = r_words_used;
        n_readable   = r_readable;
        n_push_open  = r_push_open;
        n_push_left  = r_push_left;
        n_push_len   = r_push_len;
        n_pop_open   = r_pop_open;
        n_pop_left   = r_pop_left;
        n_pop_wait   = 1'b0;
        n_pop_hdr    = r_pop_hdr;
        w_wr_en      = 1'b0;
        w_wr_data    = WORD_BITS'(i_data_word);
        w_rd_en      = 1'b0;
        w_enq        = 1'b0;
        w_res        = '0;
        w_res.status = ST_OK;

        if (w_accept) begin
            unique case (i_action)
                ACT_HEADER: begin
                    w_enq = 1'b1;
                    priority if (r_push_open ||
                                 (i_packet_length > LEN_BITS'(MAX_PACKET_WORDS))) begin
                        w_res.status = ST_SEQ;
                    end else if (w_free < w_need) begin
                        w_res.status = ST_FULL;
                    end else begin
                        w_wr_en      = 1'b1;
                        w_wr_data    = WORD_BITS'(i_packet_length);
                        n_wr_ptr     = (r_wr_ptr == PW'(STORE_DEPTH - 1)) ?
                                       '0 : r_wr_ptr + PW'(1);
                        n_words_used = r_words_used + UW'(i_packet_length) + UW'(1);
                        if (i_packet_length == '0) begin
                            n_readable = r_readable + UW'(1);
                        end else begin
                            n_push_open = 1'b1;
                            n_push_left = i_packet_length;
                            n_push_len  = i_packet_length;
                        end
                    end
                end
                ACT_DATA: begin
                    w_enq = 1'b1;
                    if (!r_push_open) begin
                        w_res.status = ST_SEQ;
                    end else begin
                        w_wr_en     = 1'b1;
                        n_wr_ptr    = (r_wr_ptr == PW'(STORE_DEPTH - 1)) ?
                                      '0 : r_wr_ptr + PW'(1);
                        n_push_left = r_push_left - LEN_BITS'(1);
                        // last word commits the whole packet
                        if (r_push_left == LEN_BITS'(1)) begin
                            n_push_open = 1'b0;
                            n_readable  = r_readable + UW'(r_push_len) + UW'(1);
                        end
                    end
                end
                ACT_POP: begin
                    if (r_readable == '0) begin
                        w_enq        = 1'b1;
                        w_res.status = ST_EMPTY;
                    end else begin
                        w_rd_en      = 1'b1;
                        n_rd_ptr     = (r_rd_ptr == PW'(STORE_DEPTH - 1)) ?
                                       '0 : r_rd_ptr + PW'(1);
                        n_words_used = r_words_used - UW'(1);
                        n_readable   = r_readable - UW'(1);
                        n_pop_wait   = 1'b1;
                        n_pop_hdr    = !r_pop_open;
                    end
                end
                default: begin
                    w_enq        = 1'b1;
                    w_res.status = ST_SEQ;
                end
            endcase
        end

        // read data is back: build the pop result
        if (r_pop_wait) begin
            w_enq           = 1'b1;
            w_res.read_word = DATA_BITS'(w_rd_data);
            if (r_pop_hdr) begin
                w_res.word_kind = KIND_HEADER;
                if (w_hdr_len == '0) begin
                    w_res.last_of_packet = 1'b1;
                end else begin
                    n_pop_open = 1'b1;
                    n_pop_left = w_hdr_len;
                end
            end else begin
                w_res.word_kind = KIND_DATA;
                n_pop_left      = r_pop_left - LEN_BITS'(1);
                if (r_pop_left == LEN_BITS'(1)) begin
                    n_pop_open           = 1'b0;
                    w_res.last_of_packet = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_words_used <= '0;
            r_readable   <= '0;
            r_push_open  <= 1'b0;
            r_push_left  <= '0;
            r_pop_open   <= 1'b0;
            r_pop_left   <= '0;
            r_pop_wait   <= 1'b0;
            r_pop_hdr    <= 1'b0;
        end else begin
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_words_used <= n_words_used;
            r_readable   <= n_readable;
            r_push_open  <= n_push_open;
            r_push_left  <= n_push_left;
            r_pop_open   <= n_pop_open;
            r_pop_left   <= n_pop_left;
            r_pop_wait   <= n_pop_wait;
            r_pop_hdr    <= n_pop_hdr;
        end
        r_push_len <= n_push_len;
    end

    // packet word store
    lppf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_data)
    );

    // result queue
    lppf_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (w_enq),
        .i_res   (w_res),
        .o_full  (w_q_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_head)
    );

    assign o_status         = w_head.status;
    assign o_word_kind      = w_head.word_kind;
    assign o_read_word      = w_head.read_word;
    assign o_last_of_packet = w_head.last_of_packet;

`ifndef SYNTHESIS
    // occupancy never exceeds the store
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words_used <= UW'(STORE_DEPTH))
        else $error("occupancy above store depth");
    // readable words are a part of the occupied words
    a_readable_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_readable <= r_words_used)
        else $error("readable count above occupancy");
    // an open packet always has words still to come
    a_push_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_push_open |-> (r_push_left != '0))
        else $error("open packet with no words left");
    // a store read is always followed by exactly one pop result
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> (r_pop_wait && w_enq && !w_rd_en && !w_wr_en))
        else $error("store read without pop result");
`endif

endmodule

/* src/lppf_ram.sv */
// lppf_ram: generic single-write, single-read synchronous ram with registered read
// no package dependencies
module lppf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/lppf_out_q.sv */
// lppf_out_q: two-entry result queue decoupling the fifo core from the output handshake
// depends on lppf_pkg (t_result)
module lppf_out_q
    import lppf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_enq,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_q0;
    t_result    r_q1;
    t_result    n_q0;
    t_result    n_q1;
    logic       w_deq;

    assign w_deq   = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_res   = r_q0;

    // next queue contents
    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        priority if (w_deq && i_enq) begin
            if (r_cnt == 2'd1) begin
                n_q0 = i_res;
            end else begin
                n_q0 = r_q1;
                n_q1 = i_res;
            end
        end else if (w_deq) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end else if (i_enq) begin
            if (r_cnt == 2'd0) begin
                n_q0 = i_res;
            end else begin
                n_q1 = i_res;
            end
            n_cnt = r_cnt + 2'd1;
        end
    end

    // count under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef SYNTHESIS
    // never enqueue into a full queue that is not draining
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_enq && (r_cnt == 2'd2) && !i_ready))
        else $error("result queue overflow");
    // count stays within two entries
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");
    // a held head entry keeps its value while stalled
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_res == $past(o_res)))
        else $error("result queue head changed while stalled");
`endif

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for length_prefixed_packet_fifo
// depends on lppf_pkg and length_prefixed_packet_fifo; predicts every result transaction
// in-bench and checks it field by field in arrival order
module testbench;
    import lppf_pkg::*;

    localparam int PTR_BITS    = $clog2(DEF_STORE_DEPTH);
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 600;

    // the one action code the block does not define
    localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_valid         = 1'b0;
    logic                   o_ready;
    logic [ACTION_BITS-1:0] i_action        = ACT_POP;
    logic [LEN_BITS-1:0]    i_packet_length = '0;
    logic [DATA_BITS-1:0]   i_data_word     = '0;
    logic                   o_valid;
    logic                   i_ready         = 1'b0;
    logic [STATUS_BITS-1:0] o_status;
    logic                   o_word_kind;
    logic [DATA_BITS-1:0]   o_read_word;
    logic                   o_last_of_packet;

    // expected results, oldest first
    t_result pending_results [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;

    // idling control shared by sender and receiver
    bit      steady = 1'b0;
    int      hold_requests = 0;
    int      holds_served = 0;
    int      hold_left = 0;

    // predicted fifo state
    logic [DATA_BITS-1:0] fifo_words [DEF_STORE_DEPTH];
    logic [PTR_BITS-1:0]  fifo_wr_ptr = '0;
    logic [PTR_BITS-1:0]  fifo_commit_ptr = '0;
    logic [PTR_BITS-1:0]  fifo_rd_ptr = '0;
    int unsigned          fifo_used = 0;
    int unsigned          fill_left = 0;
    bit                   fill_open = 1'b0;
    int unsigned          drain_left = 0;
    bit                   drain_open = 1'b0;

    length_prefixed_packet_fifo uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_packet_length  (i_packet_length),
        .i_data_word      (i_data_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_word_kind      (o_word_kind),
        .o_read_word      (o_read_word),
        .o_last_of_packet (o_last_of_packet)
    );

    always #6 i_clk = ~i_clk;

    // works out the result of one accepted transaction and moves the predicted state on
    function automatic t_result fifo_result(input logic [ACTION_BITS-1:0] act,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic [DATA_BITS-1:0] data);
        t_result             res;
        logic [PTR_BITS-1:0] span;
        int unsigned         unfinished;
        int unsigned         readable;
        logic [DATA_BITS-1:0] word;
        res.status         = ST_OK;
        res.word_kind      = KIND_HEADER;
        res.read_word      = '0;
        res.last_of_packet = 1'b0;
        // words reserved for the packet still being written are not readable
        span       = fifo_wr_ptr - fifo_commit_ptr;
        unfinished = fill_open ? span + fill_left : 0;
        readable   = (fifo_used >= unfinished) ? fifo_used - unfinished : 0;
        case (act)
            ACT_HEADER: begin
                if (fill_open || len > DEF_MAX_PACKET_WORDS) begin
                    res.status = ST_SEQ;
                end else if (DEF_STORE_DEPTH - fifo_used < len + 1) begin
                    res.status = ST_FULL;
                end else begin
                    fifo_used = fifo_used + len + 1;
                    fifo_words[fifo_wr_ptr] = DATA_BITS'(len);
                    fifo_wr_ptr = fifo_wr_ptr + 1'b1;
                    if (len == 0) begin
                        fifo_commit_ptr = fifo_wr_ptr;
                    end else begin
                        fill_open = 1'b1;
                        fill_left = len;
                    end
                end
            end
            ACT_DATA: begin
                if (!fill_open) begin
                    res.status = ST_SEQ;
                end else begin
                    fifo_words[fifo_wr_ptr] = data;
                    fifo_wr_ptr = fifo_wr_ptr + 1'b1;
                    fill_left = fill_left - 1;
                    if (fill_left == 0) begin
                        fill_open = 1'b0;
                        fifo_commit_ptr = fifo_wr_ptr;
                    end
                end
            end
            ACT_POP: begin
                if (readable == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    word = fifo_words[fifo_rd_ptr];
                    fifo_rd_ptr = fifo_rd_ptr + 1'b1;
                    fifo_used = fifo_used - 1;
                    res.read_word = word;
                    if (!drain_open) begin
                        res.word_kind = KIND_HEADER;
                        if (word[LEN_BITS-1:0] == 0) begin
                            res.last_of_packet = 1'b1;
                        end else begin
                            drain_open = 1'b1;
                            drain_left = word[LEN_BITS-1:0];
                        end
                    end else begin
                        res.word_kind = KIND_DATA;
                        drain_left = drain_left - 1;
                        if (drain_left == 0) begin
                            drain_open = 1'b0;
                            res.last_of_packet = 1'b1;
                        end
                    end
                end
            end
            default: begin
                res.status = ST_SEQ;
            end
        endcase
        return res;
    endfunction

    // offers one transaction, holds it until accepted, then records its expected result
    task automatic send_item(input logic [ACTION_BITS-1:0] act,
                             input logic [LEN_BITS-1:0] len,
                             input logic [DATA_BITS-1:0] data);
        if (!steady) begin
            while ($urandom_range(99) < 21) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_packet_length <= len;
        i_data_word     <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(fifo_result(act, len, data));
    endtask

    // sender stays quiet until every expected result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic pop_word();
        send_item(ACT_POP, LEN_BITS'($urandom), DATA_BITS'($urandom));
    endtask

    task automatic push_header(input int len);
        send_item(ACT_HEADER, LEN_BITS'(len), DATA_BITS'($urandom));
    endtask

    task automatic push_data(input logic [DATA_BITS-1:0] data);
        send_item(ACT_DATA, LEN_BITS'($urandom), data);
    endtask

    // zero-length packet, a packet not readable until complete, data extremes
    task automatic test_basic_packets();
        pop_word();
        push_header(0);
        pop_word();
        push_header(2);
        pop_word();
        push_data(16'h0000);
        push_data(16'hffff);
        pop_word();
        pop_word();
        pop_word();
        pop_word();
        wait_drained();
    endtask

    // transactions that break the packet sequence
    task automatic test_sequence_errors();
        push_data(DATA_BITS'($urandom));
        push_header(DEF_MAX_PACKET_WORDS + 1);
        push_header((1 << LEN_BITS) - 1);
        send_item(ACT_SPARE, LEN_BITS'($urandom), DATA_BITS'($urandom));
        push_header(1);
        push_header(3);
        push_data(16'ha5c3);
        pop_word();
        pop_word();
        wait_drained();
    endtask

    // result queue backs up while the receiver holds off, so the input stalls
    task automatic test_output_stall();
        hold_requests <= hold_requests + 1;
        push_header(3);
        push_data(DATA_BITS'($urandom));
        push_data(DATA_BITS'($urandom));
        push_data(DATA_BITS'($urandom));
        repeat (4) pop_word();
        push_header(0);
        pop_word();
        pop_word();
        wait_drained();
    endtask

    // fills the store to the last word with one largest-size packet and one that takes the rest, then empties it
    task automatic test_full_store();
        steady <= 1'b1;
        push_header(DEF_MAX_PACKET_WORDS);
        repeat (DEF_MAX_PACKET_WORDS) push_data(DATA_BITS'($urandom));
        push_header(DEF_MAX_PACKET_WORDS);
        push_header(DEF_MAX_PACKET_WORDS - 1);
        push_header(DEF_STORE_DEPTH - DEF_MAX_PACKET_WORDS - 2);
        repeat (DEF_STORE_DEPTH - DEF_MAX_PACKET_WORDS - 2) push_data(DATA_BITS'($urandom));
        push_header(0);
        repeat (DEF_STORE_DEPTH) pop_word();
        pop_word();
        wait_drained();
    endtask

    // mostly well-formed packets with random content, mixed with pops and broken sequences
    task automatic test_random_traffic();
        int roll;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady <= (n >= 250 && n < 350);
            roll = $urandom_range(99);
            if (roll < 8) begin
                case ($urandom_range(2))
                    0: push_header($urandom_range(DEF_MAX_PACKET_WORDS + 1, (1 << LEN_BITS) - 1));
                    1: send_item(ACT_SPARE, LEN_BITS'($urandom), DATA_BITS'($urandom));
                    default: begin
                        if (fill_open) begin
                            push_header($urandom_range((1 << LEN_BITS) - 1));
                        end else begin
                            push_data(DATA_BITS'($urandom));
                        end
                    end
                endcase
            end else if (roll < 50) begin
                pop_word();
            end else if (fill_open) begin
                push_data(DATA_BITS'($urandom));
            end else if ($urandom_range(99) < 85) begin
                push_header($urandom_range(8));
            end else begin
                push_header($urandom_range(9, 40));
            end
        end
        wait_drained();
    endtask

    // receiver: random idling, steady stretches and requested hold-offs
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            i_ready      <= 1'b0;
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 21);
        end
    end

    task automatic report_field(input string field, input logic [DATA_BITS-1:0] want,
                                input logic [DATA_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d word %0h",
                         $time, o_status, o_read_word);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", DATA_BITS'(want.status), DATA_BITS'(o_status));
                report_field("word_kind", DATA_BITS'(want.word_kind), DATA_BITS'(o_word_kind));
                report_field("read_word", want.read_word, o_read_word);
                report_field("last_of_packet", DATA_BITS'(want.last_of_packet),
                             DATA_BITS'(o_last_of_packet));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("length_prefixed_packet_fifo test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_packets();
        test_sequence_errors();
        test_output_stall();
        test_full_store();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("length_prefixed_packet_fifo test passed");
        end else begin
            $display("length_prefixed_packet_fifo test failed");
        end
        $finish;
    end

endmodule
